FILE: hw/rtl/spag_pkg.sv
// ----------------------------------------------------------------------------
// spag_pkg
// Shared types, opcodes and board helpers for the sliding piece attack
// generator.
// ----------------------------------------------------------------------------
package spag_pkg;

    localparam int BOARD_W  = 64;
    localparam int SQUARE_W = 6;
    localparam int OPCODE_W = 4;
    localparam int COORD_W  = 3;
    localparam int NUM_JUMP = 8;

    typedef logic [BOARD_W-1:0]  t_board;
    typedef logic [SQUARE_W-1:0] t_square;
    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic signed [2:0]   t_delta;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FILE   = 4'd0,
        OP_RANK   = 4'd1,
        OP_DIAG   = 4'd2,
        OP_ADIAG  = 4'd3,
        OP_ROOK   = 4'd4,
        OP_BISHOP = 4'd5,
        OP_QUEEN  = 4'd6,
        OP_KNIGHT = 4'd7,
        OP_KING   = 4'd8
    } t_opcode;

    // Line attack sets from the slider unit
    typedef struct packed {
        t_board file_l;
        t_board rank_l;
        t_board diag_l;
        t_board adiag_l;
    } t_lines;

    // Fixed jump patterns from the leaper unit
    typedef struct packed {
        t_board knight;
        t_board king;
    } t_jumps;

    // One ray walked outward from (file, rank); stops after the first blocker.
    function automatic t_board ray_fn(input t_board occ, input t_coord file,
                                      input t_coord rank, input t_delta df,
                                      input t_delta dr);
        t_board            res;
        logic              open;
        logic signed [4:0] f;
        logic signed [4:0] r;
        t_square           idx;
        res  = '0;
        open = 1'b1;
        f    = $signed({2'b00, file});
        r    = $signed({2'b00, rank});
        for (int k = 1; k < 8; k++) begin
            f = f + $signed({{2{df[2]}}, df});
            r = r + $signed({{2{dr[2]}}, dr});
            if (open && (f[4:3] == 2'b00) && (r[4:3] == 2'b00)) begin
                idx      = {r[2:0], f[2:0]};
                res[idx] = 1'b1;
                if (occ[idx]) begin
                    open = 1'b0;
                end
            end else begin
                open = 1'b0;
            end
        end
        return res;
    endfunction

    // Single jump, clipped at the board edge
    function automatic t_board jump_fn(input t_coord file, input t_coord rank,
                                       input t_delta df, input t_delta dr);
        t_board            res;
        logic signed [4:0] f;
        logic signed [4:0] r;
        res = '0;
        f   = $signed({2'b00, file}) + $signed({{2{df[2]}}, df});
        r   = $signed({2'b00, rank}) + $signed({{2{dr[2]}}, dr});
        if ((f[4:3] == 2'b00) && (r[4:3] == 2'b00)) begin
            res[{r[2:0], f[2:0]}] = 1'b1;
        end
        return res;
    endfunction

    localparam t_delta KNIGHT_DF [NUM_JUMP] = '{ 3'sd1,  3'sd2,  3'sd2,  3'sd1,
                                                -3'sd1, -3'sd2, -3'sd2, -3'sd1};
    localparam t_delta KNIGHT_DR [NUM_JUMP] = '{ 3'sd2,  3'sd1, -3'sd1, -3'sd2,
                                                -3'sd2, -3'sd1,  3'sd1,  3'sd2};
    localparam t_delta KING_DF   [NUM_JUMP] = '{ 3'sd1,  3'sd1,  3'sd0, -3'sd1,
                                                -3'sd1, -3'sd1,  3'sd0,  3'sd1};
    localparam t_delta KING_DR   [NUM_JUMP] = '{ 3'sd0,  3'sd1,  3'sd1,  3'sd1,
                                                 3'sd0, -3'sd1, -3'sd1, -3'sd1};

endpackage

FILE: hw/rtl/spag_slider.sv
// ----------------------------------------------------------------------------
// spag_slider
// Four line attack sets (file, rank, diagonal, antidiagonal) for one square.
// ----------------------------------------------------------------------------
module spag_slider (
    input  spag_pkg::t_board  i_occupancy,
    input  spag_pkg::t_square i_square,
    output spag_pkg::t_lines  o_lines
);
    import spag_pkg::*;

    t_coord file_c;
    t_coord rank_c;

    assign file_c = i_square[2:0];
    assign rank_c = i_square[5:3];

    // each line is the union of its two opposite rays
    always_comb begin
        o_lines.file_l  = ray_fn(i_occupancy, file_c, rank_c, 3'sd0, 3'sd1)
                        | ray_fn(i_occupancy, file_c, rank_c, 3'sd0, -3'sd1);
        o_lines.rank_l  = ray_fn(i_occupancy, file_c, rank_c, 3'sd1, 3'sd0)
                        | ray_fn(i_occupancy, file_c, rank_c, -3'sd1, 3'sd0);
        o_lines.diag_l  = ray_fn(i_occupancy, file_c, rank_c, 3'sd1, 3'sd1)
                        | ray_fn(i_occupancy, file_c, rank_c, -3'sd1, -3'sd1);
        o_lines.adiag_l = ray_fn(i_occupancy, file_c, rank_c, 3'sd1, -3'sd1)
                        | ray_fn(i_occupancy, file_c, rank_c, -3'sd1, 3'sd1);
    end

endmodule

FILE: hw/rtl/spag_leaper.sv
// ----------------------------------------------------------------------------
// spag_leaper
// Knight and king jump patterns for one square, clipped at the edges.
// ----------------------------------------------------------------------------
module spag_leaper (
    input  spag_pkg::t_square i_square,
    output spag_pkg::t_jumps  o_jumps
);
    import spag_pkg::*;

    t_coord file_c;
    t_coord rank_c;

    assign file_c = i_square[2:0];
    assign rank_c = i_square[5:3];

    always_comb begin
        o_jumps.knight = '0;
        o_jumps.king   = '0;
        for (int j = 0; j < NUM_JUMP; j++) begin
            o_jumps.knight = o_jumps.knight
                           | jump_fn(file_c, rank_c, KNIGHT_DF[j], KNIGHT_DR[j]);
            o_jumps.king   = o_jumps.king
                           | jump_fn(file_c, rank_c, KING_DF[j], KING_DR[j]);
        end
    end

endmodule

FILE: hw/rtl/sliding_piece_attack_generator.sv
// ----------------------------------------------------------------------------
// sliding_piece_attack_generator
// Bitboard attack sets for sliding pieces and leapers.
// ----------------------------------------------------------------------------
// Takes one query per clock while o_stall is low: opcode, 64-bit occupancy
// and origin square (a1 = 0 .. h8 = 63). Lines run from the origin up to and
// including the first blocker; rook, bishop and queen are unions of lines;
// knight and king ignore occupancy. The origin bit is never set, and opcodes
// 9..15 return an empty board. Throughput is one transfer per cycle while
// i_stall is low. A query passes through the input register, the single
// combinational ray/jump evaluation and the result register before o_valid
// rises with its result. The input side stalls only when both registers are
// full and the result is held by i_stall.
// ----------------------------------------------------------------------------
module sliding_piece_attack_generator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // query channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [3:0]        i_opcode,
    input  spag_pkg::t_board  i_occupancy,
    input  spag_pkg::t_square i_square,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output spag_pkg::t_board  o_attacks
);
    import spag_pkg::*;

    // input register stage
    logic    r_s1_valid, n_s1_valid;
    t_opcode r_s1_opcode, n_s1_opcode;
    t_board  r_s1_occ, n_s1_occ;
    t_square r_s1_square, n_s1_square;

    // result register stage
    logic    r_out_valid, n_out_valid;
    t_board  r_attacks, n_attacks;

    logic    out_free;   // result register can take a new value
    logic    s1_free;    // input register can take a new transfer
    logic    in_xfer;
    t_lines  lines;
    t_jumps  jumps;
    t_board  calc;

    spag_slider u_slider (
        .i_occupancy (r_s1_occ),
        .i_square    (r_s1_square),
        .o_lines     (lines)
    );

    spag_leaper u_leaper (
        .i_square (r_s1_square),
        .o_jumps  (jumps)
    );

    // opcode select of the attack set
    always_comb begin
        case (r_s1_opcode)
            OP_FILE:   calc = lines.file_l;
            OP_RANK:   calc = lines.rank_l;
            OP_DIAG:   calc = lines.diag_l;
            OP_ADIAG:  calc = lines.adiag_l;
            OP_ROOK:   calc = lines.file_l | lines.rank_l;
            OP_BISHOP: calc = lines.diag_l | lines.adiag_l;
            OP_QUEEN:  calc = lines.file_l | lines.rank_l
                            | lines.diag_l | lines.adiag_l;
            OP_KNIGHT: calc = jumps.knight;
            OP_KING:   calc = jumps.king;
            default:   calc = '0;
        endcase
    end

    // pipeline flow: each stage moves when the one after it has room
    assign out_free = !r_out_valid || !i_stall;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_stall  = !s1_free;
    assign in_xfer  = i_valid && s1_free;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1_opcode = r_s1_opcode;
        n_s1_occ    = r_s1_occ;
        n_s1_square = r_s1_square;
        n_out_valid = r_out_valid;
        n_attacks   = r_attacks;
        if (out_free) begin
            n_out_valid = r_s1_valid;
            n_attacks   = calc;
        end
        if (s1_free) begin
            n_s1_valid  = i_valid;
        end
        if (in_xfer) begin
            n_s1_opcode = t_opcode'(i_opcode);
            n_s1_occ    = i_occupancy;
            n_s1_square = i_square;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_opcode <= n_s1_opcode;
        r_s1_occ    <= n_s1_occ;
        r_s1_square <= n_s1_square;
        r_attacks   <= n_attacks;
    end

    assign o_valid   = r_out_valid;
    assign o_attacks = r_attacks;

    // ---- assertions ----

    // origin never appears in its own attack set
    a_no_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !calc[r_s1_square])
        else $error("origin square set in attack set");

    // a queen sees at most 27 squares
    a_queen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> ($countones(calc) <= 27))
        else $error("attack set too large");

    // input side stalls only behind a held result with work queued
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("spurious input stall");

    // a held result is not dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_attacks)))
        else $error("held result lost");

endmodule
